FILE: sv/graph6_edge_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// graph6_edge_decoder_unit_macros
// Assertion helpers for the graph6 edge decoder checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH6_EDGE_DECODER_UNIT_MACROS_SVH
`define GRAPH6_EDGE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, skipped while reset is low.
`define G6ED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is low.
`define G6ED_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/g6ed_pkg.sv
// ----------------------------------------------------------------------------
// g6ed_pkg
// Shared types, codes and constants of the graph6 edge decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package g6ed_pkg;

  localparam int VERTEX_BITS = 18;   // widest vertex count taken
  localparam int FIELD_BITS  = 18;   // width of the vertex result fields
  localparam int ACC_BITS    = 36;   // header accumulator
  localparam int DIGIT_BITS  = 6;
  localparam int QDEPTH      = 4;    // front-to-back queue depth
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_LO = 8'd63;
  localparam logic [7:0] CHAR_HI = 8'd126;
  localparam logic [DIGIT_BITS-1:0] MARKER_DIGIT = 6'd63;

  // Largest vertex count, at accumulator width plus one.
  localparam logic [ACC_BITS:0] ORDER_LIMIT =
    ((ACC_BITS+1)'(1) << VERTEX_BITS) - (ACC_BITS+1)'(1);

  typedef logic [VERTEX_BITS-1:0] vtx_t;
  typedef logic [FIELD_BITS-1:0]  field_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_COUNT = 2'd0;
  localparam kind_t KIND_EDGE  = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  typedef logic [1:0] op_t;
  localparam op_t OP_COUNT = 2'd0;   // payload is the vertex count
  localparam op_t OP_ERROR = 2'd1;
  localparam op_t OP_BODY  = 2'd2;   // payload low bits are the six data bits

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_start;
  } in_item_t;

  typedef struct packed {
    kind_t  kind;
    field_t vertex_a;
    field_t vertex_b;
    logic   last;
  } out_item_t;

  typedef struct packed {
    op_t  op;
    vtx_t payload;
  } entry_t;

  // Vertex number onto the result field: zero-extend or truncate.
  function automatic field_t to_field(vtx_t v);
    logic [FIELD_BITS+VERTEX_BITS-1:0] w;
    w = (FIELD_BITS+VERTEX_BITS)'(v);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/g6ed_front.sv
// ----------------------------------------------------------------------------
// g6ed_front
// Header parser: checks characters, gathers the vertex count, forwards body.
// ----------------------------------------------------------------------------
`default_nettype none

module g6ed_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire g6ed_pkg::in_item_t in_data,
  output logic                    q_push,
  output g6ed_pkg::entry_t        q_entry,
  input  wire logic               q_full
);
  import g6ed_pkg::*;

  localparam logic [3:0] PH_FIRST = 4'd0;
  localparam logic [3:0] PH_MARK  = 4'd1;
  localparam logic [3:0] PH_D2    = 4'd2;
  localparam logic [3:0] PH_D6    = 4'd6;
  localparam logic [3:0] PH_LAST  = 4'd7;
  localparam logic [3:0] PH_BODY  = 4'd8;
  localparam logic [3:0] PH_HALT  = 4'd9;

  logic [3:0]          phase_r, phase_nxt, ph;
  logic [ACC_BITS-1:0] acc_r, acc_nxt, acc, acc_sh, ann_val;
  logic [7:0]          code_off;
  logic [DIGIT_BITS-1:0] d;
  logic                accept, bad, do_ann;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bad      = (in_data.char_code < CHAR_LO) || (in_data.char_code > CHAR_HI);
  assign code_off = in_data.char_code - CHAR_LO;
  assign d        = code_off[DIGIT_BITS-1:0];

  always_comb begin
    ph = phase_r;
    acc = acc_r;
    if (in_data.line_start) begin
      ph  = PH_FIRST;
      acc = '0;
    end
    acc_sh    = {acc[ACC_BITS-DIGIT_BITS-1:0], d};
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    q_push    = 1'b0;
    q_entry   = '{op: OP_BODY, payload: vtx_t'(d)};
    do_ann    = 1'b0;
    ann_val   = acc_sh;
    if (accept) begin
      phase_nxt = ph;
      acc_nxt   = acc;
      if (ph >= PH_HALT) begin
        // halted line: swallow until the next line start
      end else if (bad) begin
        q_push    = 1'b1;
        q_entry   = '{op: OP_ERROR, payload: '0};
        phase_nxt = PH_HALT;
      end else begin
        case (ph)
          PH_FIRST: begin
            if (d != MARKER_DIGIT) begin
              do_ann  = 1'b1;
              ann_val = ACC_BITS'(d);
            end else begin
              phase_nxt = PH_MARK;
            end
          end
          PH_MARK: begin
            if (d != MARKER_DIGIT) begin
              acc_nxt   = ACC_BITS'(d);   // three-digit form
              phase_nxt = PH_D6;
            end else begin
              acc_nxt   = '0;             // six-digit form
              phase_nxt = PH_D2;
            end
          end
          PH_BODY: begin
            q_push = 1'b1;
          end
          default: begin
            acc_nxt = acc_sh;
            if (ph == PH_LAST) begin
              do_ann = 1'b1;
            end else begin
              phase_nxt = ph + 4'd1;
            end
          end
        endcase
        if (do_ann) begin
          q_push = 1'b1;
          if ({1'b0, ann_val} > ORDER_LIMIT) begin
            q_entry   = '{op: OP_ERROR, payload: '0};
            phase_nxt = PH_HALT;
          end else begin
            q_entry   = '{op: OP_COUNT, payload: ann_val[VERTEX_BITS-1:0]};
            phase_nxt = PH_BODY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/g6ed_queue.sv
// ----------------------------------------------------------------------------
// g6ed_queue
// Small FIFO between the header parser and the bit walker.
// ----------------------------------------------------------------------------
`default_nettype none

module g6ed_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire g6ed_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output g6ed_pkg::entry_t      head
);
  import g6ed_pkg::*;

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QAW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QAW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: sv/g6ed_back.sv
// ----------------------------------------------------------------------------
// g6ed_back
// Bit walker: one triangle position per unstalled cycle; edge hold, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module g6ed_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire g6ed_pkg::entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output g6ed_pkg::out_item_t   out_data
);
  import g6ed_pkg::*;

  logic            busy_r, busy_nxt;
  logic [5:0]      bits_r, bits_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  vtx_t            n_r, n_nxt, row_r, row_nxt, col_r, col_nxt;
  logic            done_r, done_nxt;
  logic            hold_valid_r, hold_valid_nxt, hold_last_r, hold_last_nxt;
  vtx_t            hold_a_r, hold_a_nxt, hold_b_r, hold_b_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            out_free, hit, step_go, wrap, done_step, step_end, can_load;
  logic            pop_cmd, pop_body, push_hold, push_opp;
  vtx_t            row_inc, col_inc;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign out_free  = !out_valid_r || out_ready;
  assign hit       = bits_r[5];
  // A hit with a pending edge must move that edge to the result register.
  assign step_go   = busy_r && (!(hit && hold_valid_r) || out_free);
  assign row_inc   = row_r + vtx_t'(1);
  assign col_inc   = col_r + vtx_t'(1);
  assign wrap      = (row_inc >= col_r);
  assign done_step = wrap && (col_inc >= n_r);
  assign step_end  = step_go && ((cnt_r == 3'd1) || done_step);
  assign can_load  = !busy_r || step_end;

  assign pop_body  = q_valid && can_load && (q_head.op == OP_BODY);
  assign pop_cmd   = q_valid && !busy_r && !hold_valid_r && out_free &&
                     (q_head.op != OP_BODY);
  assign q_pop     = pop_body || pop_cmd;

  assign push_hold = step_go && hit && hold_valid_r;
  assign push_opp  = hold_valid_r && hold_last_r && out_free && !push_hold;

  always_comb begin
    busy_nxt       = busy_r;
    bits_nxt       = bits_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    done_nxt       = done_r;
    hold_valid_nxt = hold_valid_r;
    hold_last_nxt  = hold_last_r;
    hold_a_nxt     = hold_a_r;
    hold_b_nxt     = hold_b_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    // walk one position
    if (step_go) begin
      bits_nxt = {bits_r[4:0], 1'b0};
      cnt_nxt  = cnt_r - 3'd1;
      if (wrap) begin
        row_nxt  = '0;
        col_nxt  = col_inc;
        done_nxt = done_r || done_step;
      end else begin
        row_nxt  = row_inc;
      end
      if (step_end) begin
        busy_nxt = 1'b0;
      end
    end

    // edge hold: an edge waits here until we know if it ends its character
    if (push_opp) begin
      hold_valid_nxt = 1'b0;
    end
    if (step_go && hit) begin
      hold_valid_nxt = 1'b1;
      hold_last_nxt  = step_end;
      hold_a_nxt     = row_r;
      hold_b_nxt     = col_r;
    end else if (step_end && hold_valid_r && !hold_last_r) begin
      hold_last_nxt  = 1'b1;
    end

    if (push_hold || push_opp) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{kind: KIND_EDGE, vertex_a: to_field(hold_a_r),
                  vertex_b: to_field(hold_b_r), last: hold_last_r};
    end

    if (pop_body && !done_nxt) begin
      busy_nxt = 1'b1;
      bits_nxt = q_head.payload[5:0];
      cnt_nxt  = 3'd6;
    end

    if (pop_cmd) begin
      out_valid_nxt = 1'b1;
      if (q_head.op == OP_COUNT) begin
        n_nxt    = q_head.payload;
        row_nxt  = '0;
        col_nxt  = vtx_t'(1);
        done_nxt = (q_head.payload <= vtx_t'(1));
        out_nxt  = '{kind: KIND_COUNT, vertex_a: to_field(q_head.payload),
                     vertex_b: '0, last: 1'b1};
      end else begin
        out_nxt  = '{kind: KIND_ERROR, vertex_a: '0, vertex_b: '0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      done_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      done_r       <= done_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    bits_r      <= bits_nxt;
    cnt_r       <= cnt_nxt;
    n_r         <= n_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    hold_last_r <= hold_last_nxt;
    hold_a_r    <= hold_a_nxt;
    hold_b_r    <= hold_b_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/graph6_edge_decoder_unit.sv
// ----------------------------------------------------------------------------
// graph6_edge_decoder_unit
// Streams graph6 text in and reports vertex count, edges and errors.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                             transaction
//   in_      input      char_code[7:0], line_start          one character
//   out_     output     kind, vertex_a, vertex_b, last      one result
//
// Flow: the front parses header characters and flags bad ones. A body character
// holds the bit walker for up to six triangle positions, one per cycle
// unless a hit waits on a stalled result; the walker loads the next one as
// it walks the last. The four-entry queue lets the front keep taking characters.
// Reset: rst_n low at a clock edge clears parser, queue and walker; the
// first character afterwards starts a line.
// Stalls: out_ready low freezes the result register and the walker once an
// edge needs to leave; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module graph6_edge_decoder_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire g6ed_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output g6ed_pkg::out_item_t      out_data
);
  import g6ed_pkg::*;

  // front -> queue
  logic   q_push, q_full;
  entry_t q_entry;
  // queue -> back
  logic   q_pop, q_valid;
  entry_t q_head;

  // Header parsing and character checks; body characters pass as raw bits.
  g6ed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  // Decouples the parser from the walker.
  g6ed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Walks the upper triangle column by column; one edge can wait in a hold
  // stage so the last flag is known before it is presented.
  g6ed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/g6ed_checker.sv
// ----------------------------------------------------------------------------
// g6ed_checker
// Port-level checks on the result channel of the graph6 edge decoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph6_edge_decoder_unit_macros.svh"

module g6ed_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire g6ed_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire g6ed_pkg::out_item_t out_data
);
  import g6ed_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && in_ready && in_data.line_start;

  // a stalled result holds
  `G6ED_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data), "result changed while stalled")

  // errors carry no vertices and close their character
  `G6ED_ASSERT_IMP(a_err_form, clk, rst_n, out_valid && out_data.kind == KIND_ERROR,
                   out_data.vertex_a == '0 && out_data.vertex_b == '0 && out_data.last,
                   "malformed error result")

  // a count announcement is a single result
  `G6ED_ASSERT_IMP(a_cnt_form, clk, rst_n, out_valid && out_data.kind == KIND_COUNT,
                   out_data.vertex_b == '0 && out_data.last && !$isunknown(in_seen),
                   "malformed count result")

endmodule

bind graph6_edge_decoder_unit g6ed_checker u_g6ed_checker (.*);

`default_nettype wire

FILE: tb/graph6_edge_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// graph6_edge_decoder_unit_test
// Self-checking bench for the graph6 edge decoder: directed header/body
// cases, then random lines and noise, with both sides throttled at random.
// ----------------------------------------------------------------------------
`default_nettype none

module graph6_edge_decoder_unit_test;
  import g6ed_pkg::*;

  localparam int ITEM_TARGET = 330;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;   // long out_ready hold-off
  localparam int DRAIN_CYCLES = 40;   // settle time after the last result
  localparam int IDLE_PCT = 36;
  localparam int QUIET_LO = 150;      // no-idle window, in accepted chars
  localparam int QUIET_HI = 200;

  // Parser phases
  localparam logic [3:0] PH_FIRST = 4'd0;        // expecting first header char
  localparam logic [3:0] PH_MARK = 4'd1;         // one marker seen
  localparam logic [3:0] PH_LONG_DIGIT = 4'd2;   // first digit of six-digit form
  localparam logic [3:0] PH_SHORT_DIGIT = 4'd6;  // second digit of three-digit form
  localparam logic [3:0] PH_LAST_DIGIT = 4'd7;
  localparam logic [3:0] PH_BODY = 4'd8;
  localparam logic [3:0] PH_HALT = 4'd9;

  typedef struct packed {
    in_item_t chr;
    logic     drain_first;   // wait for every result before offering
    logic     hold_rx;       // receiver starts its long hold-off on accept
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  graph6_edge_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expected-result stores; newest entry at index 0, oldest at $
  stim_t     char_stream[$];
  out_item_t graph_events[$];
  stim_t     next_char;
  logic      cur_hold = 1'b0;
  logic      hold_go = 1'b0;
  int        hold_left = 0;
  int        live_chars = 0;
  int        chars_taken = 0;
  int        cycle_count = 0;
  int        in_stalls = 0;
  int        mismatches = 0;
  int        counts_seen = 0;
  int        edges_seen = 0;
  int        errors_seen = 0;
  bit        quiet;

  // Decoder state mirror
  logic [3:0]  parse_phase;
  logic [35:0] order_acc;
  logic [35:0] tri_row;
  logic [35:0] tri_col;
  logic        tri_done;

  assign quiet = (chars_taken >= QUIET_LO) && (chars_taken < QUIET_HI);

  function automatic void clear_line();
    parse_phase = PH_FIRST;
    order_acc = '0;
    tri_row = '0;
    tri_col = 36'd1;
    tri_done = 1'b0;
  endfunction

  function automatic out_item_t make_event(kind_t k, logic [35:0] a, logic [35:0] b);
    out_item_t e;
    e.kind = k;
    e.vertex_a = a[FIELD_BITS-1:0];
    e.vertex_b = b[FIELD_BITS-1:0];
    e.last = 1'b0;
    return e;
  endfunction

  // Header complete: either the vertex count or an order-too-large error.
  function automatic out_item_t announce(logic [35:0] n);
    if ({1'b0, n} > ORDER_LIMIT) begin
      parse_phase = PH_HALT;
      return make_event(KIND_ERROR, '0, '0);
    end
    order_acc = n;
    parse_phase = PH_BODY;
    tri_row = '0;
    tri_col = 36'd1;
    tri_done = (n <= 36'd1);
    return make_event(KIND_COUNT, n, '0);
  endfunction

  // Work out the results one accepted character causes and queue them.
  task automatic decode_char(input in_item_t c);
    logic [5:0] d;
    out_item_t  res[$];
    int         b;
    int         j;
    if (c.line_start) clear_line();
    if (parse_phase >= PH_HALT) return;
    if (c.char_code < CHAR_LO || c.char_code > CHAR_HI) begin
      parse_phase = PH_HALT;
      res.push_front(make_event(KIND_ERROR, '0, '0));
    end else begin
      d = 6'(c.char_code - CHAR_LO);
      case (parse_phase)
        PH_FIRST: begin
          if (d != MARKER_DIGIT) res.push_front(announce({30'd0, d}));
          else parse_phase = PH_MARK;
        end
        PH_MARK: begin
          // A second marker selects the six-digit form.
          if (d != MARKER_DIGIT) begin
            order_acc = {30'd0, d};
            parse_phase = PH_SHORT_DIGIT;
          end else begin
            order_acc = '0;
            parse_phase = PH_LONG_DIGIT;
          end
        end
        PH_BODY: begin
          // Column-major walk of the upper triangle, MSB first.
          for (b = 5; b >= 0 && !tri_done; b--) begin
            if (d[b]) res.push_front(make_event(KIND_EDGE, tri_row, tri_col));
            tri_row++;
            if (tri_row >= tri_col) begin
              tri_row = '0;
              tri_col++;
              if (tri_col >= order_acc) tri_done = 1'b1;
            end
          end
        end
        default: begin
          order_acc = {order_acc[29:0], d};
          if (parse_phase == PH_LAST_DIGIT) res.push_front(announce(order_acc));
          else parse_phase++;
        end
      endcase
    end
    // res holds the newest result at index 0
    if (res.size() > 0) res[0].last = 1'b1;
    for (j = res.size() - 1; j >= 0; j--) graph_events.push_front(res[j]);
  endtask

  task automatic add_char(input logic [7:0] code, input logic ls, input bit live,
                          input bit drain, input bit hold);
    stim_t s;
    s.chr.char_code = code;
    s.chr.line_start = ls;
    s.drain_first = drain;
    s.hold_rx = hold;
    char_stream.push_front(s);
    if (live) live_chars++;
  endtask

  // One graph6 line: header in the given form (0 one char, 1 three digits,
  // 2 six digits), then up to body_cap body chars, then pad ignored chars.
  task automatic gen_line(input logic [35:0] n, input int form, input int density,
                          input int body_cap, input int pad, input bit drain,
                          input bit hold);
    logic [5:0] d;
    int         nbody;
    int         k;
    int         b;
    if (form == 0) begin
      add_char(CHAR_LO + 8'(n[5:0]), 1'b1, 1'b1, drain, hold);
    end else begin
      add_char(CHAR_HI, 1'b1, 1'b1, drain, hold);
      if (form == 2) add_char(CHAR_HI, 1'b0, 1'b1, 1'b0, 1'b0);
      for (k = (form == 2) ? 5 : 2; k >= 0; k--)
        add_char(CHAR_LO + 8'(n[6*k +: 6]), 1'b0, 1'b1, 1'b0, 1'b0);
    end
    if (n <= 36'd64) nbody = (int'(n) * (int'(n) - 1) / 2 + 5) / 6;
    else nbody = body_cap;
    if (nbody > body_cap) nbody = body_cap;
    for (k = 0; k < nbody + pad; k++) begin
      d = '0;
      for (b = 0; b < 6; b++)
        if ($urandom_range(1, 100) <= density) d[b] = 1'b1;
      add_char(CHAR_LO + 8'(d), 1'b0, k < nbody, 1'b0, 1'b0);
    end
  endtask

  // Driver: a held transaction changes only once accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_go <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_data);
        chars_taken <= chars_taken + 1;
      end
      if (in_valid && !in_ready) in_stalls <= in_stalls + 1;
      hold_go <= in_valid && in_ready && cur_hold;
      if (!in_valid || in_ready) begin
        if (char_stream.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT) &&
            !(char_stream[$].drain_first && graph_events.size() != 0)) begin
          next_char = char_stream.pop_back();
          in_valid <= 1'b1;
          in_data <= next_char.chr;
          cur_hold <= next_char.hold_rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver throttle; the long hold-off lets the block back up into in_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [35:0] want,
                             input logic [35:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (graph_events.size() == 0) begin
        $error("unexpected result: kind %0d vertex_a %0d vertex_b %0d last %0b",
               out_data.kind, out_data.vertex_a, out_data.vertex_b, out_data.last);
        mismatches++;
      end else begin
        want = graph_events.pop_back();
        check_field("kind", 36'(want.kind), 36'(out_data.kind));
        check_field("vertex_a", 36'(want.vertex_a), 36'(out_data.vertex_a));
        check_field("vertex_b", 36'(want.vertex_b), 36'(out_data.vertex_b));
        check_field("last", 36'(want.last), 36'(out_data.last));
        if (want.kind == KIND_COUNT) counts_seen++;
        else if (want.kind == KIND_EDGE) edges_seen++;
        else errors_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [35:0] n;
    int          pick;
    int          k;
    bit          hold_done;
    bit          drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    clear_line();

    // Directed: first char after reset without a line start (n = 0), then a
    // body char past an empty triangle.
    add_char(8'd63, 1'b0, 1'b1, 1'b0, 1'b0);
    add_char(8'd100, 1'b0, 1'b0, 1'b0, 1'b0);
    // n = 1, tiny graph
    add_char(8'd64, 1'b1, 1'b1, 1'b0, 1'b0);
    // n = 4, all body bits set: every edge of the graph from one char
    add_char(8'd67, 1'b1, 1'b1, 1'b0, 1'b0);
    add_char(CHAR_HI, 1'b0, 1'b1, 1'b0, 1'b0);
    // Bad char below range starting a line
    add_char(8'd62, 1'b1, 1'b1, 1'b0, 1'b0);
    // Three-digit form n = 125, then a bad char above range, then halted input
    add_char(CHAR_HI, 1'b1, 1'b1, 1'b0, 1'b0);
    add_char(8'd63, 1'b0, 1'b1, 1'b0, 1'b0);
    add_char(8'd64, 1'b0, 1'b1, 1'b0, 1'b0);
    add_char(8'd124, 1'b0, 1'b1, 1'b0, 1'b0);
    add_char(8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
    add_char(8'd90, 1'b0, 1'b0, 1'b0, 1'b0);
    // Six-digit form at the largest legal order, then one past it
    gen_line(36'd262143, 2, 50, 0, 0, 1'b0, 1'b0);
    gen_line(36'd262144, 2, 50, 0, 0, 1'b0, 1'b0);

    // Random lines: mostly well-formed, some broken, some noise.
    while (live_chars < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!hold_done && live_chars >= 100) begin
        hold_done = 1'b1;
        gen_line(36'd12, 0, 100, 1000, 0, 1'b0, 1'b1);
      end else if (!drain_done && live_chars >= 230) begin
        drain_done = 1'b1;
        gen_line(36'($urandom_range(2, 10)), 0, 50, 1000, 0, 1'b1, 1'b0);
      end else if (pick < 58) begin
        gen_line(36'($urandom_range(0, 14)), 0, $urandom_range(0, 100), 1000,
                 $urandom_range(0, 2), 1'b0, 1'b0);
      end else if (pick < 70) begin
        n = {18'd0, 6'($urandom_range(0, 62)), 12'($urandom)};
        gen_line(n, 1, $urandom_range(0, 100), $urandom_range(1, 4), 0, 1'b0, 1'b0);
      end else if (pick < 78) begin
        if ($urandom_range(0, 1) == 0) begin
          n = 36'($urandom_range(0, 262143));
          gen_line(n, 2, $urandom_range(0, 100), $urandom_range(1, 4), 0, 1'b0, 1'b0);
        end else begin
          n = {4'($urandom), 32'($urandom)};
          gen_line(n, 2, 50, ({1'b0, n} > ORDER_LIMIT) ? 0 : 2, 0, 1'b0, 1'b0);
        end
      end else if (pick < 90) begin
        // Broken line: a bad char cuts it short, trailing chars are ignored
        if ($urandom_range(0, 1) == 0)
          gen_line(36'($urandom_range(2, 9)), 0, 50, $urandom_range(0, 2), 0, 1'b0, 1'b0);
        else
          gen_line({18'd0, 6'($urandom_range(0, 62)), 12'($urandom)}, 1, 50, 0, 0,
                   1'b0, 1'b0);
        if ($urandom_range(0, 1) == 0)
          add_char(8'($urandom_range(0, 62)), $urandom_range(0, 3) == 0, 1'b1, 1'b0, 1'b0);
        else
          add_char(8'($urandom_range(127, 255)), $urandom_range(0, 3) == 0, 1'b1, 1'b0,
                   1'b0);
        for (k = $urandom_range(0, 2); k > 0; k--)
          add_char(8'($urandom_range(63, 126)), 1'b0, 1'b0, 1'b0, 1'b0);
      end else begin
        // Noise: any code, line start at random
        for (k = $urandom_range(1, 4); k > 0; k--)
          add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (char_stream.size() != 0 || in_valid) @(posedge clk);
    while (graph_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d characters accepted, giving %0d vertex counts, %0d edges, %0d errors.",
             chars_taken, counts_seen, edges_seen, errors_seen);
    $display("Input back-pressured for %0d cycles; finished after %0d cycles.",
             in_stalls, cycle_count);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
